FILE: hw/rtl/cpv_pkg.sv
`default_nettype none

package cpv_pkg;

	// fixed field widths
	localparam int unsigned COORD_W    = 32;
	localparam int unsigned POINT_W    = 40;
	localparam int unsigned TYPE_W     = 8;
	localparam int unsigned PROD_W     = 2 * COORD_W;
	localparam int unsigned SCALE_W    = 32;
	localparam int unsigned TOL_W      = 24;
	localparam int unsigned INDEX_W    = 32;
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned IN_USER_W  = 9;
	localparam int unsigned OUT_DATA_W = 312;
	localparam int unsigned OUT_USER_W = 4;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// parameter defaults
	localparam int unsigned FRACTION_BITS_DEF = 16;
	localparam int unsigned COUNT_WIDTH_DEF   = 32;

	// a contour with at least this many nodes is kept
	localparam logic [1:0] NODE_SAT = 2'd2;

	// signed 40-bit range of a scaled magnitude
	localparam logic [PROD_W-1:0] POS_LIMIT = 64'h0000_007F_FFFF_FFFF;
	localparam logic [PROD_W-1:0] NEG_LIMIT = 64'h0000_0080_0000_0000;

	// element types
	localparam logic [TYPE_W-1:0] ELEM_START   = 8'd0;
	localparam logic [TYPE_W-1:0] ELEM_CONTROL = 8'd1;
	localparam logic [TYPE_W-1:0] ELEM_CURVE   = 8'd2;
	localparam logic [TYPE_W-1:0] ELEM_LINE    = 8'd3;

	// register indexes (paddr[2])
	localparam logic REG_MM_PER_UNIT = 1'b0;
	localparam logic REG_WELD_TOL    = 1'b1;

	typedef enum logic [2:0] {
		KIND_MOVE    = 3'd0,
		KIND_LINE    = 3'd1,
		KIND_CUBIC   = 3'd2,
		KIND_KEPT    = 3'd3,
		KIND_DROPPED = 3'd4,
		KIND_ERROR   = 3'd5,
		KIND_DONE    = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		ISSUE_NONE          = 4'd0,
		ISSUE_CURVE_NO_CTRL = 4'd1,
		ISSUE_BAD_CURVE     = 4'd2,
		ISSUE_CTRL_BEFORE   = 4'd3,
		ISSUE_DANGLING      = 4'd4,
		ISSUE_BEFORE_START  = 4'd5,
		ISSUE_UNKNOWN_TYPE  = 4'd6,
		ISSUE_OVERFLOW      = 4'd7,
		ISSUE_BAD_SCALE     = 4'd8,
		ISSUE_BAD_TOL       = 4'd9
	} issue_t;

	typedef enum logic [1:0] {
		PS_AWAIT   = 2'd0,
		PS_CONTOUR = 2'd1,
		PS_ONE     = 2'd2,
		PS_TWO     = 2'd3
	} parse_state_t;

	typedef struct packed {
		logic                      ovf;
		logic signed [POINT_W-1:0] value;
	} scaled_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpv_coord_scale.sv
`default_nettype none

module cpv_coord_scale (
	input  logic                              clk,
	input  logic                              load,
	input  logic [cpv_pkg::COORD_W-1:0]       mag,
	input  logic                              neg,
	input  logic [cpv_pkg::SCALE_W-1:0]       scale,
	output cpv_pkg::scaled_t                  result
);
	import cpv_pkg::*;

	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;

	// magnitude times scale, registered
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(scale);
			neg_s2  <= neg;
		end
	end

	// range check and sign restore
	always_comb begin
		result.ovf   = neg_s2 ? (prod_s2 > NEG_LIMIT) : (prod_s2 > POS_LIMIT);
		result.value = neg_s2 ? POINT_W'(~prod_s2[POINT_W-1:0] + POINT_W'(1))
		                      : prod_s2[POINT_W-1:0];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/curve_path_command_validator.sv
`default_nettype none

// channel   | direction | handshake                     | contents
// ----------+-----------+-------------------------------+------------------------------------
// s_axis    | in        | tvalid & tready               | one path element per request
// m_axis    | out       | tvalid & tready               | move/line/cubic, markers, error, done
// apb       | in        | psel & penable & pwrite       | mm_per_unit (0x0), weld_tolerance (0x4)
//
// an element passes an input register, a registered 32x32 multiply per axis and a
// decision stage that writes the output register
// an element that closes a contour or ends the stream gives several results, one per cycle
// while m_axis is ready, up to four, through the single output register
// arst_n clears all control state; config reads back, weld_tolerance is only stored
// a stall on m_axis holds the decision stage, then the multiply and input registers

module curve_path_command_validator #(
	parameter int unsigned FRACTION_BITS = cpv_pkg::FRACTION_BITS_DEF,
	parameter int unsigned COUNT_WIDTH   = cpv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// element stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [cpv_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // coord_x, coord_y
	input  logic [cpv_pkg::IN_USER_W-1:0]      s_axis_tuser,  // element_type, closed_mark
	input  logic                               s_axis_tlast,  // last_element
	// command stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// point_x, point_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, issue, element_index, tally, pad
	output logic [cpv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [cpv_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // kind, closed
	output logic                               m_axis_tlast,  // last_result
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cpv_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [cpv_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [cpv_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import cpv_pkg::*;

	localparam logic [SCALE_W-1:0] MM_RESET = SCALE_W'(64'd1 << FRACTION_BITS);

	// result slots of one element, emitted lowest first
	localparam logic [3:0] SLOT_PRE  = 4'b0001;  // marker closing the previous contour
	localparam logic [3:0] SLOT_MAIN = 4'b0010;  // segment or error
	localparam logic [3:0] SLOT_POST = 4'b0100;  // marker closing the current contour
	localparam logic [3:0] SLOT_DONE = 4'b1000;  // stream done

	// ---------------- configuration registers ----------------
	logic [SCALE_W-1:0] mm_per_unit_q;
	logic [TOL_W-1:0]   weld_tol_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_per_unit_q <= MM_RESET;
			weld_tol_q    <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MM_PER_UNIT: mm_per_unit_q <= pwdata;
				REG_WELD_TOL:    weld_tol_q    <= pwdata[TOL_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MM_PER_UNIT: prdata = mm_per_unit_q;
			REG_WELD_TOL:    prdata = CFG_DATA_W'(weld_tol_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- pipeline handshake ----------------
	logic valid_s1, valid_s2;
	logic load_s1, load_s2, en_s2, finish;

	assign en_s2         = !valid_s2 || finish;
	assign s_axis_tready = !valid_s1 || en_s2;
	assign load_s1       = s_axis_tvalid & s_axis_tready;
	assign load_s2       = valid_s1 & en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)      valid_s1 <= 1'b1;
			else if (load_s2) valid_s1 <= 1'b0;
			if (load_s2)      valid_s2 <= 1'b1;
			else if (finish)  valid_s2 <= 1'b0;
		end
	end

	// ---------------- input register: magnitudes and signs ----------------
	logic [COORD_W-1:0] in_x, in_y;
	logic [COORD_W-1:0] magx_s1, magy_s1;
	logic               negx_s1, negy_s1;
	logic [TYPE_W-1:0]  type_s1, type_s2;
	logic               mark_s1, mark_s2;
	logic               last_s1, last_s2;

	assign in_x = s_axis_tdata[COORD_W-1:0];
	assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];

	always_ff @(posedge clk) begin
		if (load_s1) begin
			negx_s1 <= in_x[COORD_W-1];
			negy_s1 <= in_y[COORD_W-1];
			magx_s1 <= in_x[COORD_W-1] ? COORD_W'(~in_x + COORD_W'(1)) : in_x;
			magy_s1 <= in_y[COORD_W-1] ? COORD_W'(~in_y + COORD_W'(1)) : in_y;
			type_s1 <= s_axis_tuser[TYPE_W-1:0];
			mark_s1 <= s_axis_tuser[TYPE_W];
			last_s1 <= s_axis_tlast;
		end
	end

	// ---------------- multiply stage ----------------
	scaled_t sx, sy;

	cpv_coord_scale u_scale_x (
		.clk    (clk),
		.load   (load_s2),
		.mag    (magx_s1),
		.neg    (negx_s1),
		.scale  (mm_per_unit_q),
		.result (sx)
	);

	cpv_coord_scale u_scale_y (
		.clk    (clk),
		.load   (load_s2),
		.mag    (magy_s1),
		.neg    (negy_s1),
		.scale  (mm_per_unit_q),
		.result (sy)
	);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			type_s2 <= type_s1;
			mark_s2 <= mark_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stream state ----------------
	parse_state_t             ps_q, ps_d;
	logic [POINT_W-1:0]       cp_q [4];
	logic                     closed_q, closed_d;
	logic [1:0]               node_q, node_d;
	logic [COUNT_WIDTH-1:0]   elem_q, elem_d;
	logic [COUNT_WIDTH-1:0]   sub_q, sub_d;
	logic [COUNT_WIDTH-1:0]   kept_q, kept_d;
	logic                     discard_q, discard_d;
	logic [3:0]               sent_q;
	logic                     cp_wr_lo, cp_wr_hi;

	// ---------------- decision: classify the element ----------------
	logic   is_err, seg_ok, ctrl_ok;
	issue_t err_issue;
	kind_t  seg_kind;

	always_comb begin
		is_err    = 1'b0;
		seg_ok    = 1'b0;
		ctrl_ok   = 1'b0;
		err_issue = ISSUE_NONE;
		seg_kind  = KIND_MOVE;
		// scale first, then coordinates, then order
		if (mm_per_unit_q == '0) begin
			is_err    = 1'b1;
			err_issue = ISSUE_BAD_SCALE;
		end else if (sx.ovf || sy.ovf) begin
			is_err    = 1'b1;
			err_issue = ISSUE_OVERFLOW;
		end else begin
			unique case (type_s2)
				ELEM_START: begin
					if (ps_q == PS_ONE || ps_q == PS_TWO) begin
						is_err    = 1'b1;
						err_issue = ISSUE_DANGLING;
					end else begin
						seg_ok   = 1'b1;
						seg_kind = KIND_MOVE;
					end
				end
				ELEM_CONTROL: begin
					if (ps_q == PS_AWAIT) begin
						is_err    = 1'b1;
						err_issue = ISSUE_BEFORE_START;
					end else if (ps_q == PS_TWO) begin
						is_err    = 1'b1;
						err_issue = ISSUE_BAD_CURVE;
					end else if (last_s2) begin
						// stream ends with a control pending
						is_err    = 1'b1;
						err_issue = ISSUE_DANGLING;
					end else begin
						ctrl_ok = 1'b1;
					end
				end
				ELEM_CURVE: begin
					if (ps_q == PS_AWAIT) begin
						is_err    = 1'b1;
						err_issue = ISSUE_BEFORE_START;
					end else if (ps_q != PS_TWO) begin
						is_err    = 1'b1;
						err_issue = ISSUE_CURVE_NO_CTRL;
					end else begin
						seg_ok   = 1'b1;
						seg_kind = KIND_CUBIC;
					end
				end
				ELEM_LINE: begin
					if (ps_q == PS_AWAIT) begin
						is_err    = 1'b1;
						err_issue = ISSUE_BEFORE_START;
					end else if (ps_q != PS_CONTOUR) begin
						is_err    = 1'b1;
						err_issue = ISSUE_CTRL_BEFORE;
					end else begin
						seg_ok   = 1'b1;
						seg_kind = KIND_LINE;
					end
				end
				default: begin
					is_err    = 1'b1;
					err_issue = ISSUE_UNKNOWN_TYPE;
				end
			endcase
		end
	end

	// ---------------- decision: which results, and their contour facts ----------------
	logic                   is_move;
	logic [3:0]             slot_mask, rem, slot_oh;
	logic                   slot_last;
	logic                   kept_pre, kept_post, closed_post;
	logic [COUNT_WIDTH-1:0] kept_after;

	assign is_move = seg_kind == KIND_MOVE;

	always_comb begin
		slot_mask = '0;
		if (!discard_q) begin
			if (seg_ok && is_move && ps_q != PS_AWAIT) slot_mask = slot_mask | SLOT_PRE;
			if (seg_ok || is_err)                      slot_mask = slot_mask | SLOT_MAIN;
			if (seg_ok && last_s2)                     slot_mask = slot_mask | SLOT_POST | SLOT_DONE;
		end
	end

	assign kept_pre    = node_q >= NODE_SAT;
	// a move restarts the count at one node, a segment adds one
	assign kept_post   = !is_move && node_q != 2'd0;
	assign closed_post = is_move ? mark_s2 : (closed_q | mark_s2);
	assign kept_after  = kept_q
		+ COUNT_WIDTH'(slot_mask[0] & kept_pre)
		+ COUNT_WIDTH'(slot_mask[2] & kept_post);

	assign rem = slot_mask & ~sent_q;

	always_comb begin
		priority if (rem[0]) slot_oh = SLOT_PRE;
		else if (rem[1])     slot_oh = SLOT_MAIN;
		else if (rem[2])     slot_oh = SLOT_POST;
		else if (rem[3])     slot_oh = SLOT_DONE;
		else                 slot_oh = '0;
	end

	assign slot_last = (rem & ~slot_oh) == '0;

	// ---------------- output register ----------------
	logic                  out_valid_q;
	logic                  out_load;
	kind_t                 row_kind;
	logic                  row_closed;
	logic [POINT_W-1:0]    row_px, row_py, row_c1x, row_c1y, row_c2x, row_c2y;
	issue_t                row_issue;
	logic [INDEX_W-1:0]    row_idx, row_tally;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;
	logic                  out_last_q;

	assign out_load = valid_s2 && rem != '0 && (!out_valid_q || m_axis_tready);
	assign finish   = valid_s2 && (rem == '0 || (out_load && slot_last));

	always_comb begin
		row_kind   = KIND_MOVE;
		row_closed = 1'b0;
		row_px     = '0;
		row_py     = '0;
		row_c1x    = '0;
		row_c1y    = '0;
		row_c2x    = '0;
		row_c2y    = '0;
		row_issue  = ISSUE_NONE;
		row_idx    = '0;
		row_tally  = '0;
		unique case (slot_oh)
			SLOT_PRE: begin
				row_kind   = kept_pre ? KIND_KEPT : KIND_DROPPED;
				row_closed = closed_q;
			end
			SLOT_MAIN: begin
				if (is_err) begin
					row_kind  = KIND_ERROR;
					row_issue = err_issue;
					row_idx   = INDEX_W'(elem_q);
					row_tally = INDEX_W'(sub_q);
				end else begin
					row_kind = seg_kind;
					row_px   = sx.value;
					row_py   = sy.value;
					if (seg_kind == KIND_CUBIC) begin
						row_c1x = cp_q[0];
						row_c1y = cp_q[1];
						row_c2x = cp_q[2];
						row_c2y = cp_q[3];
					end
				end
			end
			SLOT_POST: begin
				row_kind   = kept_post ? KIND_KEPT : KIND_DROPPED;
				row_closed = closed_post;
			end
			SLOT_DONE: begin
				row_kind  = KIND_DONE;
				row_tally = INDEX_W'(kept_after);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'b0, row_tally, row_idx, row_issue,
			               row_c2y, row_c2x, row_c1y, row_c1x, row_py, row_px};
			out_user_q <= {row_closed, row_kind};
			out_last_q <= slot_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	// ---------------- stream state update, once per element ----------------
	always_comb begin
		ps_d      = ps_q;
		closed_d  = closed_q;
		node_d    = node_q;
		elem_d    = elem_q + COUNT_WIDTH'(1);
		sub_d     = sub_q;
		kept_d    = kept_q;
		discard_d = discard_q;
		cp_wr_lo  = 1'b0;
		cp_wr_hi  = 1'b0;
		if (last_s2) begin
			// every stream ends back in the reset state
			ps_d      = PS_AWAIT;
			closed_d  = 1'b0;
			node_d    = '0;
			elem_d    = '0;
			sub_d     = '0;
			kept_d    = '0;
			discard_d = 1'b0;
		end else if (discard_q) begin
			// dropping until the end of the stream
		end else if (is_err) begin
			discard_d = 1'b1;
		end else if (ctrl_ok) begin
			cp_wr_lo = ps_q == PS_CONTOUR;
			cp_wr_hi = ps_q == PS_ONE;
			ps_d     = (ps_q == PS_CONTOUR) ? PS_ONE : PS_TWO;
			closed_d = closed_q | mark_s2;
		end else if (seg_ok && is_move) begin
			if (slot_mask[0]) begin
				sub_d  = sub_q + COUNT_WIDTH'(1);
				kept_d = kept_after;
			end
			node_d   = 2'd1;
			closed_d = mark_s2;
			ps_d     = PS_CONTOUR;
		end else if (seg_ok) begin
			node_d   = (node_q >= NODE_SAT) ? NODE_SAT : node_q + 2'd1;
			closed_d = closed_q | mark_s2;
			ps_d     = PS_CONTOUR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q      <= PS_AWAIT;
			closed_q  <= 1'b0;
			node_q    <= '0;
			elem_q    <= '0;
			sub_q     <= '0;
			kept_q    <= '0;
			discard_q <= 1'b0;
			sent_q    <= '0;
		end else begin
			if (finish) begin
				ps_q      <= ps_d;
				closed_q  <= closed_d;
				node_q    <= node_d;
				elem_q    <= elem_d;
				sub_q     <= sub_d;
				kept_q    <= kept_d;
				discard_q <= discard_d;
				sent_q    <= '0;
			end else if (out_load) begin
				sent_q <= sent_q | slot_oh;
			end
		end
	end

	// control points, read only after both are written in the same stream
	always_ff @(posedge clk) begin
		if (finish && cp_wr_lo) begin
			cp_q[0] <= sx.value;
			cp_q[1] <= sy.value;
		end
		if (finish && cp_wr_hi) begin
			cp_q[2] <= sx.value;
			cp_q[3] <= sy.value;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cpv_checker.sv
`default_nettype none

module cpv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cpv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [cpv_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);
	import cpv_pkg::*;

	// no result while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// error and done always close the results of their element
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == KIND_ERROR || m_axis_tuser[2:0] == KIND_DONE)
		|-> m_axis_tlast)
		else $error("error or done not marked last");

	// issue code only on error results
	a_issue_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != KIND_ERROR |-> m_axis_tdata[243:240] == ISSUE_NONE)
		else $error("issue code outside error result");

	// contour markers carry no points
	a_marker_pts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == KIND_KEPT || m_axis_tuser[2:0] == KIND_DROPPED)
		|-> m_axis_tdata[239:0] == '0)
		else $error("contour marker with point data");

	// stalled request holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind curve_path_command_validator cpv_checker u_cpv_checker (.*);

`default_nettype wire
